// File: hw/rtl/mandelbrot_escape_iterator_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef MANDELBROT_ESCAPE_ITERATOR_MACROS_SVH
`define MANDELBROT_ESCAPE_ITERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mbe_pkg.sv
package mbe_pkg;

  localparam int PIX_W   = 12;
  localparam int DIM_W   = 13;
  localparam int ITER_W  = 16;
  localparam int CFG_IDX_W = 3;
  // Magnitude of pixel times viewport span fits in 44 bits.
  localparam int NUM_W   = 44;
  localparam int PROD_W  = 46;
  localparam int ESCAPE_RADIUS_SQ = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd6;

  localparam logic [ITER_W-1:0] RST_ITER_LIMIT = 16'd256;
  localparam logic signed [31:0] RST_REAL_MIN  = -32'sd536870912;
  localparam logic signed [31:0] RST_REAL_MAX  = 32'sd268435456;
  localparam logic signed [31:0] RST_IMAG_MIN  = -32'sd402653184;
  localparam logic signed [31:0] RST_IMAG_MAX  = 32'sd402653184;
  localparam logic [DIM_W-1:0] RST_WIDTH       = 13'd1024;
  localparam logic [DIM_W-1:0] RST_HEIGHT      = 13'd1024;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic              escaped;
    logic [ITER_W-1:0] escape_count;
  } result_t;

  typedef struct packed {
    logic [ITER_W-1:0] iteration_limit;
    logic signed [31:0] real_min;
    logic signed [31:0] real_max;
    logic signed [31:0] imag_min;
    logic signed [31:0] imag_max;
    logic [DIM_W-1:0]  width_pixels;
    logic [DIM_W-1:0]  height_pixels;
  } cfg_t;

  typedef struct packed {
    logic load_pixel;
    logic div_start;
    logic div_sel_y;
    logic load_cx;
    logic load_cy;
    logic mul;
    logic update;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic escape;
    logic at_limit;
  } status_t;

  // Clamp a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if ((&v[64:31]) || !(|v[64:31])) begin
      r = v[31:0];
    end else if (v[64]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/mbe_divider.sv
module mbe_divider #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quot_r, quot_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem_r, quot_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      quot_nxt = num;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[DEN_W-1:0];
      end
      quot_nxt = {quot_r[NUM_W-2:0], fits};
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: hw/rtl/mbe_datapath.sv
module mbe_datapath #(
  parameter int FRAC_BITS = 28,
  parameter int MAX_DIM   = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mbe_pkg::cfg_t    cfg,
  input  mbe_pkg::pixel_t  in_word,
  input  mbe_pkg::cmd_t    cmd,
  output mbe_pkg::status_t st,
  output mbe_pkg::result_t out_word
);

  localparam int DEN_W = $clog2(MAX_DIM + 1);
  localparam int NUM_W = mbe_pkg::NUM_W;
  localparam int PROD_W = mbe_pkg::PROD_W;
  localparam int ITER_W = mbe_pkg::ITER_W;
  localparam logic [63:0] ESC_LIM = 64'(mbe_pkg::ESCAPE_RADIUS_SQ) << FRAC_BITS;

  mbe_pkg::pixel_t  pix_r, pix_nxt;
  mbe_pkg::result_t res_r, res_nxt;
  logic               neg_r, neg_nxt;
  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [31:0] zx_r, zx_nxt, zy_r, zy_nxt;
  logic signed [63:0] xx_r, xx_nxt, yy_r, yy_nxt, xy_r, xy_nxt;
  logic [ITER_W-1:0]  it_r, it_nxt;

  logic signed [32:0]     span_x, span_y;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_sel, prod_mag;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       den_x, den_y;
  logic                   div_done;
  logic [NUM_W-1:0]       div_quot;
  logic signed [PROD_W-1:0] q_abs, q_s, map_x, map_y;
  logic signed [31:0]     map_cx, map_cy;
  logic signed [63:0]     re_diff, re_sh, im_sh;
  logic signed [31:0]     nx, ny;
  logic [63:0]            mag;
  logic                   escape;

  function automatic logic [DEN_W-1:0] clamp_dim(input logic [mbe_pkg::DIM_W-1:0] dim);
    logic [31:0] d;
    d = 32'(dim);
    if (d == 32'd0) begin
      d = 32'd1;
    end else if (d > 32'(MAX_DIM)) begin
      d = 32'(MAX_DIM);
    end
    return d[DEN_W-1:0];
  endfunction

  // Viewport mapping: product of pixel and span, then a shared divider.
  assign span_x = {cfg.real_max[31], cfg.real_max} - {cfg.real_min[31], cfg.real_min};
  assign span_y = {cfg.imag_max[31], cfg.imag_max} - {cfg.imag_min[31], cfg.imag_min};
  assign prod_x = $signed({{(PROD_W - mbe_pkg::PIX_W){1'b0}}, pix_r.pixel_x}) *
                  $signed({{(PROD_W - 33){span_x[32]}}, span_x});
  assign prod_y = $signed({{(PROD_W - mbe_pkg::PIX_W){1'b0}}, pix_r.pixel_y}) *
                  $signed({{(PROD_W - 33){span_y[32]}}, span_y});
  assign prod_sel = cmd.div_sel_y ? prod_y : prod_x;
  assign prod_mag = prod_sel[PROD_W-1] ? -prod_sel : prod_sel;
  assign div_num  = prod_mag[NUM_W-1:0];
  assign den_x = clamp_dim(cfg.width_pixels);
  assign den_y = clamp_dim(cfg.height_pixels);

  mbe_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (cmd.div_sel_y ? den_y : den_x),
    .done  (div_done),
    .quot  (div_quot)
  );

  // The quotient truncates toward zero, so the sign is applied to the magnitude.
  assign q_abs = {{(PROD_W - NUM_W){1'b0}}, div_quot};
  assign q_s   = neg_r ? -q_abs : q_abs;
  assign map_x = {{(PROD_W - 32){cfg.real_min[31]}}, cfg.real_min} + q_s;
  assign map_y = {{(PROD_W - 32){cfg.imag_min[31]}}, cfg.imag_min} + q_s;
  assign map_cx = mbe_pkg::sat32({{(65 - PROD_W){map_x[PROD_W-1]}}, map_x});
  assign map_cy = mbe_pkg::sat32({{(65 - PROD_W){map_y[PROD_W-1]}}, map_y});

  // z update from the registered products; arithmetic shifts give the floor.
  assign re_diff = xx_r - yy_r;
  assign re_sh   = re_diff >>> FRAC_BITS;
  assign im_sh   = xy_r >>> (FRAC_BITS - 1);
  assign nx = mbe_pkg::sat32({re_sh[63], re_sh} + {{33{cx_r[31]}}, cx_r});
  assign ny = mbe_pkg::sat32({im_sh[63], im_sh} + {{33{cy_r[31]}}, cy_r});

  // The squares of the current z double as the escape test of the last update.
  assign mag    = ($unsigned(xx_r) >> FRAC_BITS) + ($unsigned(yy_r) >> FRAC_BITS);
  assign escape = (it_r != '0) && (mag > ESC_LIM);

  always_comb begin
    pix_nxt = pix_r;
    res_nxt = res_r;
    neg_nxt = neg_r;
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    zx_nxt  = zx_r;
    zy_nxt  = zy_r;
    xx_nxt  = xx_r;
    yy_nxt  = yy_r;
    xy_nxt  = xy_r;
    it_nxt  = it_r;
    if (cmd.load_pixel) begin
      pix_nxt = in_word;
    end
    if (cmd.div_start) begin
      neg_nxt = prod_sel[PROD_W-1];
    end
    if (cmd.load_cx) begin
      cx_nxt = map_cx;
      zx_nxt = map_cx;
    end
    if (cmd.load_cy) begin
      cy_nxt = map_cy;
      zy_nxt = map_cy;
      it_nxt = '0;
    end
    if (cmd.mul) begin
      xx_nxt = 64'(zx_r) * 64'(zx_r);
      yy_nxt = 64'(zy_r) * 64'(zy_r);
      xy_nxt = 64'(zx_r) * 64'(zy_r);
    end
    if (cmd.update) begin
      zx_nxt = nx;
      zy_nxt = ny;
      it_nxt = it_r + ITER_W'(1);
    end
    if (cmd.load_result) begin
      res_nxt.escaped      = escape;
      res_nxt.escape_count = escape ? it_r - ITER_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    res_r <= res_nxt;
    neg_r <= neg_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    zx_r  <= zx_nxt;
    zy_r  <= zy_nxt;
    xx_r  <= xx_nxt;
    yy_r  <= yy_nxt;
    xy_r  <= xy_nxt;
    it_r  <= it_nxt;
  end

  assign st.div_done = div_done;
  assign st.escape   = escape;
  assign st.at_limit = it_r == cfg.iteration_limit;
  assign out_word    = res_r;

endmodule

// File: hw/rtl/mbe_ctrl.sv
module mbe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mbe_pkg::status_t st,
  output mbe_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MAPX  = 7'b0000010,
    S_WAITX = 7'b0000100,
    S_MAPY  = 7'b0001000,
    S_WAITY = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_UPD   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_pixel = 1'b1;
          state_nxt      = S_MAPX;
        end
      end
      S_MAPX: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAITX;
      end
      S_WAITX: begin
        if (st.div_done) begin
          cmd.load_cx = 1'b1;
          state_nxt   = S_MAPY;
        end
      end
      S_MAPY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_nxt     = S_WAITY;
      end
      S_WAITY: begin
        if (st.div_done) begin
          cmd.load_cy = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // A finished word holds here until the output register is free.
        if (st.escape || st.at_limit) begin
          if (out_free) begin
            cmd.load_result = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.update = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/mandelbrot_escape_iterator.sv
// Steps: accept a pixel in S_IDLE, map x and y with two 44-step divisions (S_MAPX, S_WAITX,
// S_MAPY, S_WAITY), then run S_MUL and S_UPD once per z update, N updates in all, where N
// is the escape index plus one, or the iteration limit; S_UPD then loads the result.
// One pixel in flight: the next word is taken in S_IDLE after the result loads, and
// S_UPD holds the finished pixel while the output register waits.
// Reset (synchronous, rst_n low): controller idle, no result pending, config at defaults.
`include "mandelbrot_escape_iterator_macros.svh"

module mandelbrot_escape_iterator #(
  parameter int FRAC_BITS = 28,
  parameter int MAX_DIM   = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mbe_pkg::pixel_t                 in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mbe_pkg::result_t                out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  mbe_pkg::cfg_t    cfg_r, cfg_nxt;
  mbe_pkg::cmd_t    cmd;
  mbe_pkg::status_t st;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        mbe_pkg::CFG_ITER_LIMIT: cfg_nxt.iteration_limit = cfg_data[mbe_pkg::ITER_W-1:0];
        mbe_pkg::CFG_REAL_MIN:   cfg_nxt.real_min = $signed(cfg_data);
        mbe_pkg::CFG_REAL_MAX:   cfg_nxt.real_max = $signed(cfg_data);
        mbe_pkg::CFG_IMAG_MIN:   cfg_nxt.imag_min = $signed(cfg_data);
        mbe_pkg::CFG_IMAG_MAX:   cfg_nxt.imag_max = $signed(cfg_data);
        mbe_pkg::CFG_WIDTH:      cfg_nxt.width_pixels = cfg_data[mbe_pkg::DIM_W-1:0];
        mbe_pkg::CFG_HEIGHT:     cfg_nxt.height_pixels = cfg_data[mbe_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.iteration_limit <= mbe_pkg::RST_ITER_LIMIT;
      cfg_r.real_min        <= mbe_pkg::RST_REAL_MIN;
      cfg_r.real_max        <= mbe_pkg::RST_REAL_MAX;
      cfg_r.imag_min        <= mbe_pkg::RST_IMAG_MIN;
      cfg_r.imag_max        <= mbe_pkg::RST_IMAG_MAX;
      cfg_r.width_pixels    <= mbe_pkg::RST_WIDTH;
      cfg_r.height_pixels   <= mbe_pkg::RST_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mbe_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_word  (in_word),
    .cmd      (cmd),
    .st       (st),
    .out_word (out_word)
  );

  `MBE_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.load_result, !out_valid || out_ready, "result word overwritten before it was taken")
  `MBE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "second word accepted while a pixel is in flight")
  `MBE_ASSERT_NOW(a_update_only_live, clk, rst_n, cmd.update, !st.escape && !st.at_limit, "z updated after escape or at the iteration limit")
  `MBE_ASSERT_NOW(a_count_zero_bounded, clk, rst_n, out_valid && !out_word.escaped, out_word.escape_count == '0, "bounded result carries a nonzero count")

endmodule

// File: tb/mandelbrot_escape_iterator_test.sv
module mandelbrot_escape_iterator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  localparam int FRAC_BITS = 28;
  localparam int MAX_DIM = 4096;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS = 150;
  // The slowest pixel runs 65535 z updates and never escapes.
  localparam int unsigned QUIET_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pixel_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic cfg_t default_config();
    cfg_t c;
    c.iteration_limit = RST_ITER_LIMIT;
    c.real_min = RST_REAL_MIN;
    c.real_max = RST_REAL_MAX;
    c.imag_min = RST_IMAG_MIN;
    c.imag_max = RST_IMAG_MAX;
    c.width_pixels = RST_WIDTH;
    c.height_pixels = RST_HEIGHT;
    return c;
  endfunction

  class escape_scoreboard;
    cfg_t regs;
    result_t expected_results[$];
    int failures;

    function new();
      regs = default_config();
      failures = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_ITER_LIMIT: regs.iteration_limit = data[ITER_W-1:0];
        CFG_REAL_MIN:   regs.real_min = data;
        CFG_REAL_MAX:   regs.real_max = data;
        CFG_IMAG_MIN:   regs.imag_min = data;
        CFG_IMAG_MAX:   regs.imag_max = data;
        CFG_WIDTH:      regs.width_pixels = data[DIM_W-1:0];
        CFG_HEIGHT:     regs.height_pixels = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
      if (v < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
      return v;
    endfunction

    // Division truncates toward zero, as the hardware divider does.
    function longint map_axis(longint p, longint lo, longint hi, longint dim);
      longint den;
      den = dim;
      if (den < 1) den = 1;
      if (den > MAX_DIM) den = MAX_DIM;
      return clamp32(lo + (p * (hi - lo)) / den);
    endfunction

    function result_t predict_escape(pixel_t p);
      longint cx, cy, zx, zy, nx, ny, mag;
      int unsigned n;
      result_t r;
      r = '0;
      cx = map_axis(longint'(p.pixel_x), longint'($signed(regs.real_min)),
                    longint'($signed(regs.real_max)), longint'(regs.width_pixels));
      cy = map_axis(longint'(p.pixel_y), longint'($signed(regs.imag_min)),
                    longint'($signed(regs.imag_max)), longint'(regs.height_pixels));
      zx = cx;
      zy = cy;
      for (n = 0; n < regs.iteration_limit; n++) begin
        nx = clamp32(((zx * zx - zy * zy) >>> FRAC_BITS) + cx);
        ny = clamp32(((zx * zy) >>> (FRAC_BITS - 1)) + cy);
        mag = ((nx * nx) >>> FRAC_BITS) + ((ny * ny) >>> FRAC_BITS);
        if (mag > (longint'(ESCAPE_RADIUS_SQ) <<< FRAC_BITS)) begin
          r.escaped = 1'b1;
          r.escape_count = n[ITER_W-1:0];
          return r;
        end
        zx = nx;
        zy = ny;
      end
      return r;
    endfunction

    function void note_pixel(pixel_t p);
      expected_results.insert(expected_results.size(), predict_escape(p));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result word: escaped %0d count %0d",
                   got.escaped, got.escape_count);
        return;
      end
      want = expected_results.pop_front();
      if (got.escaped !== want.escaped || got.escape_count !== want.escape_count) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("result mismatch: expected escaped %0d count %0d, got escaped %0d count %0d",
                   want.escaped, want.escape_count, got.escaped, got.escape_count);
      end
    endfunction
  endclass

  escape_scoreboard board;

  mandelbrot_escape_iterator #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        board.check_result(out_word);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pixel_t pix(int x, int y);
    pixel_t p;
    p.pixel_x = x[PIX_W-1:0];
    p.pixel_y = y[PIX_W-1:0];
    return p;
  endfunction

  function automatic int effective_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  // Returns {min, max} for one axis, mostly a window around the set.
  function automatic logic [63:0] random_axis();
    int lo, span;
    if ($urandom_range(7) == 0) return {$urandom(), $urandom()};
    lo = -671088640 + int'($urandom_range(0, 805306368));
    span = int'($urandom_range(1048576, 805306368));
    if ($urandom_range(4) == 0) return {lo + span, lo};
    return {lo, lo + span};
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
      default: return DIM_W'($urandom_range(1, MAX_DIM));
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    if ($urandom_range(5) == 0)
      c.iteration_limit = ITER_W'($urandom_range(49, 300));
    else
      c.iteration_limit = ITER_W'($urandom_range(1, 48));
    {c.real_min, c.real_max} = random_axis();
    {c.imag_min, c.imag_max} = random_axis();
    c.width_pixels = random_dim();
    c.height_pixels = random_dim();
    return c;
  endfunction

  // Mostly pixels inside the image; now and then any 12-bit coordinate.
  function automatic pixel_t random_pixel(cfg_t c);
    pixel_t p;
    if ($urandom_range(9) == 0) begin
      p.pixel_x = PIX_W'($urandom());
      p.pixel_y = PIX_W'($urandom());
    end else begin
      p.pixel_x = PIX_W'($urandom_range(0, effective_dim(c.width_pixels) - 1));
      p.pixel_y = PIX_W'($urandom_range(0, effective_dim(c.height_pixels) - 1));
    end
    return p;
  endfunction

  // Leaves cfg_valid high so that back-to-back writes need no gap.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.note_config(idx, data);
  endtask

  // Unused upper data bits carry junk, which the narrow registers must drop.
  task automatic load_config(cfg_t c, bit poke_unused);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CFG_ITER_LIMIT, {junk[31:16], c.iteration_limit});
    write_reg(CFG_REAL_MIN, c.real_min);
    write_reg(CFG_REAL_MAX, c.real_max);
    write_reg(CFG_IMAG_MIN, c.imag_min);
    write_reg(CFG_IMAG_MAX, c.imag_max);
    write_reg(CFG_WIDTH, {junk[31:13], c.width_pixels});
    write_reg(CFG_HEIGHT, {junk[18:0], c.height_pixels});
    if (poke_unused) write_reg(CFG_UNUSED, junk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= p;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    int ph;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: field extremes, a bounded point and alternating bit patterns.
    send_pixel(pix(0, 0));
    send_pixel(pix(4095, 4095));
    send_pixel(pix(512, 512));
    send_pixel(pix(12'hAAA, 12'h555));
    drain();

    // A zero iteration limit never escapes; also write the unused index.
    c = default_config();
    c.iteration_limit = '0;
    load_config(c, 1'b1);
    send_pixel(pix(512, 512));
    send_pixel(pix(4095, 0));
    drain();

    // Full-range viewport, zero width and an oversized height; c saturates.
    c.iteration_limit = 16'd1;
    c.real_min = 32'sh8000_0000;
    c.real_max = 32'sh7FFF_FFFF;
    c.imag_min = 32'sh8000_0000;
    c.imag_max = 32'sh7FFF_FFFF;
    c.width_pixels = '0;
    c.height_pixels = 13'd8191;
    load_config(c, 1'b0);
    send_pixel(pix(0, 0));
    send_pixel(pix(1, 4095));
    send_pixel(pix(4095, 2048));
    drain();

    // Reversed viewport on both axes.
    c.iteration_limit = 16'd20;
    c.real_min = 32'sd268435456;
    c.real_max = -32'sd536870912;
    c.imag_min = 32'sd402653184;
    c.imag_max = -32'sd402653184;
    c.width_pixels = 13'd4096;
    c.height_pixels = 13'd1;
    load_config(c, 1'b0);
    send_pixel(pix(0, 0));
    send_pixel(pix(2048, 0));
    send_pixel(pix(4095, 1));
    send_pixel(pix(100, 3));
    drain();

    // Largest limit: one point deep inside the set, one that leaves at once.
    c = default_config();
    c.iteration_limit = 16'hFFFF;
    load_config(c, 1'b0);
    send_pixel(pix(682, 512));
    send_pixel(pix(4095, 4095));
    drain();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      c = random_config();
      load_config(c, 1'($urandom_range(1)));
      repeat (PHASE_ITEMS) send_pixel(random_pixel(c));
      drain();
    end

    // A stray word after the last one expected would show up here.
    repeat (200) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
